// ===== rtl/hog_pkg.sv =====
package hog_pkg;

   // Frame geometry and histogram shape
   localparam int CELL_ROWS = 16;
   localparam int CELL_COLS = 8;
   localparam int CELL_SIDE = 8;
   localparam int BINS      = 9;

   localparam int PIX_COUNT   = CELL_SIDE * CELL_SIDE;
   localparam int PIX_W       = $clog2(PIX_COUNT);
   localparam int COL_W       = $clog2(CELL_COLS);
   localparam int ROW_W       = $clog2(CELL_ROWS);
   localparam int BIN_IDX_W   = $clog2(BINS);
   localparam int BIN_VAL_W   = 15;
   localparam int BIN_MAX     = 32767;
   localparam int STORE_DEPTH = 2 * CELL_COLS * BINS;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);
   localparam int BLOCK_LEN   = 4 * BINS;
   localparam int BLK_W       = $clog2(BLOCK_LEN);
   localparam int SUM_W       = 2 * BIN_VAL_W + $clog2(BLOCK_LEN);
   localparam int SQRT_W      = 32;
   localparam int ROOT_W      = SQRT_W / 2;

   // tan(20k degrees) scaled by 2^32, k = 1..4
   localparam logic [63:0] TAN_Q32 [4] = '{
      64'd1563240253, 64'd3603905474, 64'd7439101574, 64'd24357969942
   };

   typedef struct packed {
      logic [7:0] grad_x;
      logic [7:0] grad_y;
   } req_type;

   typedef struct packed {
      logic [15:0] norm_value;
      logic        block_last;
   } rsp_type;

   // One block waiting for normalization: row parity and column of cell (r+1,c+1)
   typedef struct packed {
      logic             parity;
      logic [COL_W-1:0] col;
   } job_type;

   typedef struct packed {
      logic job_pop;
      logic copy_busy;
   } back_status_type;

endpackage

// ===== rtl/hog_ram.sv =====
module hog_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, read one entry with registered data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/hog_isqrt.sv =====
module hog_isqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [hog_pkg::SQRT_W-1:0]  value,
   output logic                        done,
   output logic [hog_pkg::ROOT_W-1:0]  root
);
   import hog_pkg::*;

   logic [SQRT_W-1:0] x_ff, x_in;
   logic [SQRT_W-1:0] r_ff, r_in;
   logic [SQRT_W-1:0] b_ff, b_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [SQRT_W:0]   trial;

   // One result bit per cycle, bit pair by bit pair from the top
   always_comb begin
      x_in    = x_ff;
      r_in    = r_ff;
      b_in    = b_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {1'b0, r_ff} + {1'b0, b_ff};
      if (start) begin
         x_in    = value;
         r_in    = '0;
         b_in    = SQRT_W'(1) << (SQRT_W - 2);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if ({1'b0, x_ff} >= trial) begin
            x_in = x_ff - trial[SQRT_W-1:0];
            r_in = (r_ff >> 1) + b_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         b_in = b_ff >> 2;
         if (b_ff == SQRT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff <= x_in;
      r_ff <= r_in;
      b_ff <= b_in;
   end

   assign done = done_ff;
   assign root = r_ff[ROOT_W-1:0];

endmodule

// ===== rtl/hog_front.sv =====
module hog_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  hog_pkg::req_type                req_data,
   output logic                            store_wr_en,
   output logic [hog_pkg::STORE_AW-1:0]    store_wr_addr,
   output logic [hog_pkg::BIN_VAL_W-1:0]   store_wr_data,
   output logic                            job_valid,
   output hog_pkg::job_type                job,
   input  hog_pkg::back_status_type        back_status
);
   import hog_pkg::*;

   localparam logic [1:0] F_IDLE  = 2'd0;
   localparam logic [1:0] F_MAG   = 2'd1;
   localparam logic [1:0] F_WAIT  = 2'd2;
   localparam logic [1:0] F_FLUSH = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [BIN_VAL_W-1:0] bins_ff [BINS];
   logic [BIN_VAL_W-1:0] bins_in [BINS];
   logic [BIN_IDX_W-1:0] bin_ff, bin_in;
   logic [BIN_IDX_W-1:0] flush_ff, flush_in;
   logic [PIX_W-1:0]     pix_ff, pix_in;
   logic [COL_W-1:0]     col_ff, col_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic                 job_valid_ff, job_valid_in;
   job_type              job_ff, job_in;
   logic                 accept;
   logic [16:0]          mag_sq;
   logic [2:0]           angle_cnt;
   logic [BIN_IDX_W-1:0] pix_bin;
   logic                 sqrt_done;
   logic [ROOT_W-1:0]    mag;
   logic [ROOT_W:0]      acc_sum;

   assign accept   = req_push && !req_full;
   assign req_full = (state_ff != F_IDLE);

   // Squared magnitude and orientation bin of the incoming pixel
   always_comb begin
      mag_sq    = 17'({8'd0, req_data.grad_x} * {8'd0, req_data.grad_x})
                + 17'({8'd0, req_data.grad_y} * {8'd0, req_data.grad_y});
      angle_cnt = '0;
      for (int k = 0; k < 4; k++) begin
         if ((64'(req_data.grad_y) << 32) >= 64'(req_data.grad_x) * TAN_Q32[k]) begin
            angle_cnt = angle_cnt + 3'd1;
         end
      end
      if (req_data.grad_x == 8'd0) begin
         pix_bin = '0;
      end else if (32'(angle_cnt) > BINS - 1) begin
         pix_bin = BIN_IDX_W'(BINS - 1);
      end else begin
         pix_bin = BIN_IDX_W'(angle_cnt);
      end
   end

   hog_isqrt u_mag_sqrt (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .value (SQRT_W'(mag_sq)),
      .done  (sqrt_done),
      .root  (mag)
   );

   assign acc_sum = {1'b0, (ROOT_W)'(bins_ff[bin_ff])} + {1'b0, mag};

   // Accumulate pixels, then write the finished cell to the row store
   always_comb begin
      state_in     = state_ff;
      bins_in      = bins_ff;
      bin_in       = bin_ff;
      flush_in     = flush_ff;
      pix_in       = pix_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      job_valid_in = job_valid_ff;
      job_in       = job_ff;
      if (back_status.job_pop) begin
         job_valid_in = 1'b0;
      end
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               bin_in   = pix_bin;
               state_in = F_MAG;
            end
         end
         F_MAG: begin
            if (sqrt_done) begin
               if (acc_sum > (ROOT_W + 1)'(BIN_MAX)) begin
                  bins_in[bin_ff] = BIN_VAL_W'(BIN_MAX);
               end else begin
                  bins_in[bin_ff] = acc_sum[BIN_VAL_W-1:0];
               end
               if (pix_ff == PIX_W'(PIX_COUNT - 1)) begin
                  pix_in   = '0;
                  state_in = F_WAIT;
               end else begin
                  pix_in   = pix_ff + PIX_W'(1);
                  state_in = F_IDLE;
               end
            end
         end
         F_WAIT: begin
            // hold until the pending block has been copied out of the store
            if (!job_valid_ff && !back_status.copy_busy) begin
               flush_in = '0;
               state_in = F_FLUSH;
            end
         end
         F_FLUSH: begin
            for (int i = 0; i < BINS - 1; i++) begin
               bins_in[i] = bins_ff[i+1];
            end
            bins_in[BINS-1] = '0;
            if (flush_ff == BIN_IDX_W'(BINS - 1)) begin
               if (row_ff != '0 && col_ff != '0) begin
                  job_valid_in  = 1'b1;
                  job_in.parity = row_ff[0];
                  job_in.col    = col_ff;
               end
               if (col_ff == COL_W'(CELL_COLS - 1)) begin
                  col_in = '0;
                  if (row_ff == ROW_W'(CELL_ROWS - 1)) begin
                     row_in = '0;
                  end else begin
                     row_in = row_ff + ROW_W'(1);
                  end
               end else begin
                  col_in = col_ff + COL_W'(1);
               end
               state_in = F_IDLE;
            end else begin
               flush_in = flush_ff + BIN_IDX_W'(1);
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= F_IDLE;
         pix_ff       <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         job_valid_ff <= 1'b0;
         for (int i = 0; i < BINS; i++) begin
            bins_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         pix_ff       <= pix_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         job_valid_ff <= job_valid_in;
         bins_ff      <= bins_in;
      end
      bin_ff   <= bin_in;
      flush_ff <= flush_in;
      job_ff   <= job_in;
   end

   assign store_wr_en   = (state_ff == F_FLUSH);
   assign store_wr_addr = STORE_AW'((32'(row_ff[0]) * CELL_COLS + 32'(col_ff)) * BINS
                                    + 32'(flush_ff));
   assign store_wr_data = bins_ff[0];
   assign job_valid     = job_valid_ff;
   assign job           = job_ff;

endmodule

// ===== rtl/hog_back.sv =====
module hog_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            job_valid,
   input  hog_pkg::job_type                job,
   output hog_pkg::back_status_type        back_status,
   output logic                            store_rd_en,
   output logic [hog_pkg::STORE_AW-1:0]    store_rd_addr,
   input  logic [hog_pkg::BIN_VAL_W-1:0]   store_rd_data,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output hog_pkg::rsp_type                rsp_data
);
   import hog_pkg::*;

   localparam logic [2:0] B_IDLE = 3'd0;
   localparam logic [2:0] B_COPY = 3'd1;
   localparam logic [2:0] B_READ = 3'd2;
   localparam logic [2:0] B_SQ   = 3'd3;
   localparam logic [2:0] B_CHK  = 3'd4;
   localparam logic [2:0] B_DIV  = 3'd5;
   localparam logic [2:0] B_SQRT = 3'd6;
   localparam logic [2:0] B_OUT  = 3'd7;

   localparam int CNT_W = $clog2(BLOCK_LEN + 2);
   localparam int Q_W   = 32;

   logic [2:0]             state_ff, state_in;
   job_type                job_ff, job_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [1:0]             quad_ff, quad_in;
   logic [BIN_IDX_W-1:0]   bsel_ff, bsel_in;
   logic                   rd_valid_ff, rd_valid_in;
   logic [BLK_W-1:0]       rd_idx_ff, rd_idx_in;
   logic                   prod_valid_ff, prod_valid_in;
   logic [2*BIN_VAL_W-1:0] prod_ff, prod_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [BLK_W-1:0]       idx_ff, idx_in;
   logic [2*BIN_VAL_W-1:0] a2_ff, a2_in;
   logic [SUM_W:0]         rem_ff, rem_in;
   logic [Q_W-1:0]         quo_ff, quo_in;
   logic [4:0]             div_ff, div_in;
   logic [15:0]            val_ff, val_in;
   logic                   out_valid_ff, out_valid_in;
   rsp_type                out_ff, out_in;
   logic                   sqrt_start;
   logic                   sqrt_done;
   logic [ROOT_W-1:0]      root;
   logic                   cell_par;
   logic [COL_W-1:0]       cell_col;
   logic                   loc_rd_en;
   logic [BIN_VAL_W-1:0]   loc_rd_data;
   logic [SUM_W:0]         rem_shift;

   // Cells of the block in order (r,c),(r+1,c),(r,c+1),(r+1,c+1)
   assign cell_par      = quad_ff[0] ? job_ff.parity : ~job_ff.parity;
   assign cell_col      = quad_ff[1] ? job_ff.col : job_ff.col - COL_W'(1);
   assign store_rd_en   = (state_ff == B_COPY) && (32'(cnt_ff) < BLOCK_LEN);
   assign store_rd_addr = STORE_AW'((32'(cell_par) * CELL_COLS + 32'(cell_col)) * BINS
                                    + 32'(bsel_ff));

   assign back_status.job_pop   = (state_ff == B_IDLE) && job_valid;
   assign back_status.copy_busy = (state_ff == B_COPY);

   // Local copy of the block, so the row store is released early
   hog_ram #(
      .WIDTH (BIN_VAL_W),
      .DEPTH (BLOCK_LEN)
   ) u_block_ram (
      .clock   (clock),
      .wr_en   (rd_valid_ff),
      .wr_addr (rd_idx_ff),
      .wr_data (store_rd_data),
      .rd_en   (loc_rd_en),
      .rd_addr (idx_ff),
      .rd_data (loc_rd_data)
   );

   assign loc_rd_en = (state_ff == B_READ);

   // Start the root on the final quotient, including its last bit
   hog_isqrt u_norm_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_start),
      .value (quo_in),
      .done  (sqrt_done),
      .root  (root)
   );

   assign sqrt_start = (state_ff == B_DIV) && (div_ff == 5'd31);
   assign rem_shift  = rem_ff << 1;

   // Copy and sum squares, then divide and root each value in turn
   always_comb begin
      state_in      = state_ff;
      job_in        = job_ff;
      cnt_in        = cnt_ff;
      quad_in       = quad_ff;
      bsel_in       = bsel_ff;
      rd_valid_in   = 1'b0;
      rd_idx_in     = rd_idx_ff;
      prod_valid_in = rd_valid_ff;
      prod_in       = (2 * BIN_VAL_W)'(store_rd_data) * (2 * BIN_VAL_W)'(store_rd_data);
      sum_in        = sum_ff;
      idx_in        = idx_ff;
      a2_in         = a2_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      div_in        = div_ff;
      val_in        = val_ff;
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      if (rsp_pop && out_valid_ff) begin
         out_valid_in = 1'b0;
      end
      if (prod_valid_ff) begin
         sum_in = sum_ff + SUM_W'(prod_ff);
      end
      case (state_ff)
         B_IDLE: begin
            if (job_valid) begin
               job_in   = job;
               cnt_in   = '0;
               quad_in  = '0;
               bsel_in  = '0;
               sum_in   = '0;
               state_in = B_COPY;
            end
         end
         B_COPY: begin
            if (32'(cnt_ff) < BLOCK_LEN) begin
               rd_valid_in = 1'b1;
               rd_idx_in   = BLK_W'(cnt_ff);
               if (bsel_ff == BIN_IDX_W'(BINS - 1)) begin
                  bsel_in = '0;
                  quad_in = quad_ff + 2'd1;
               end else begin
                  bsel_in = bsel_ff + BIN_IDX_W'(1);
               end
            end
            if (cnt_ff == CNT_W'(BLOCK_LEN + 1)) begin
               idx_in   = '0;
               state_in = B_READ;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         B_READ: begin
            state_in = B_SQ;
         end
         B_SQ: begin
            a2_in    = (2 * BIN_VAL_W)'(loc_rd_data) * (2 * BIN_VAL_W)'(loc_rd_data);
            state_in = B_CHK;
         end
         B_CHK: begin
            if (sum_ff == '0) begin
               val_in   = '0;
               state_in = B_OUT;
            end else if (SUM_W'(a2_ff) >= sum_ff) begin
               val_in   = 16'hFFFF;
               state_in = B_OUT;
            end else begin
               rem_in   = (SUM_W + 1)'(a2_ff);
               quo_in   = '0;
               div_in   = '0;
               state_in = B_DIV;
            end
         end
         B_DIV: begin
            if (rem_shift >= {1'b0, sum_ff}) begin
               rem_in = rem_shift - {1'b0, sum_ff};
               quo_in = {quo_ff[Q_W-2:0], 1'b1};
            end else begin
               rem_in = rem_shift;
               quo_in = {quo_ff[Q_W-2:0], 1'b0};
            end
            if (div_ff == 5'd31) begin
               state_in = B_SQRT;
            end else begin
               div_in = div_ff + 5'd1;
            end
         end
         B_SQRT: begin
            if (sqrt_done) begin
               val_in   = root;
               state_in = B_OUT;
            end
         end
         B_OUT: begin
            // hold until the output register is free
            if (!out_valid_ff) begin
               out_valid_in      = 1'b1;
               out_in.norm_value = val_ff;
               out_in.block_last = (idx_ff == BLK_W'(BLOCK_LEN - 1));
               if (idx_ff == BLK_W'(BLOCK_LEN - 1)) begin
                  state_in = B_IDLE;
               end else begin
                  idx_in   = idx_ff + BLK_W'(1);
                  state_in = B_READ;
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= B_IDLE;
         rd_valid_ff   <= 1'b0;
         prod_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_valid_ff   <= rd_valid_in;
         prod_valid_ff <= prod_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      job_ff    <= job_in;
      cnt_ff    <= cnt_in;
      quad_ff   <= quad_in;
      bsel_ff   <= bsel_in;
      rd_idx_ff <= rd_idx_in;
      prod_ff   <= prod_in;
      sum_ff    <= sum_in;
      idx_ff    <= idx_in;
      a2_ff     <= a2_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      div_ff    <= div_in;
      val_ff    <= val_in;
      out_ff    <= out_in;
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

// ===== rtl/hog_cell_histogram_block_norm.sv =====
// HOG cell histogram and block normalizer. Push one pixel's absolute gradient
// pair per transfer, cell by cell in row-major cell order. Each pixel is held
// in the front end while the bit-serial magnitude square root runs, and
// req_full stays high until it is done; the last pixel of a cell then writes
// the cell, bin by bin, into the two-row store. Once cell (r+1,c+1) is
// written, 36 Q0.16 values of block (r,c) follow, with block_last on the
// 36th. The back end copies the block into a local buffer and then takes the
// values one by one through a 32-step divider and a 16-step square root;
// one more block may wait between the two halves, and req_full stays high at
// a cell end until the waiting block has been copied out of the store.
module hog_cell_histogram_block_norm (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  hog_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output hog_pkg::rsp_type rsp_data
);
   import hog_pkg::*;

   logic                 store_wr_en;
   logic [STORE_AW-1:0]  store_wr_addr;
   logic [BIN_VAL_W-1:0] store_wr_data;
   logic                 store_rd_en;
   logic [STORE_AW-1:0]  store_rd_addr;
   logic [BIN_VAL_W-1:0] store_rd_data;
   logic                 job_valid;
   job_type              job;
   back_status_type      back_status;

   hog_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_data      (req_data),
      .store_wr_en   (store_wr_en),
      .store_wr_addr (store_wr_addr),
      .store_wr_data (store_wr_data),
      .job_valid     (job_valid),
      .job           (job),
      .back_status   (back_status)
   );

   // Histograms of the two most recent cell rows
   hog_ram #(
      .WIDTH (BIN_VAL_W),
      .DEPTH (STORE_DEPTH)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (store_wr_en),
      .wr_addr (store_wr_addr),
      .wr_data (store_wr_data),
      .rd_en   (store_rd_en),
      .rd_addr (store_rd_addr),
      .rd_data (store_rd_data)
   );

   hog_back u_back (
      .clock         (clock),
      .reset         (reset),
      .job_valid     (job_valid),
      .job           (job),
      .back_status   (back_status),
      .store_rd_en   (store_rd_en),
      .store_rd_addr (store_rd_addr),
      .store_rd_data (store_rd_data),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_data      (rsp_data)
   );

endmodule

// ===== verif/hog_norm_checker.sv =====
module hog_norm_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  logic             req_full,
   input  hog_pkg::req_type req_data,
   input  logic             rsp_empty,
   input  logic             rsp_pop,
   input  hog_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending,
   output int               blocks_done
);
   import hog_pkg::*;

   // Histogram state mirrored from the pixel stream
   logic [BIN_VAL_W-1:0] cell_hist [BINS];
   logic [BIN_VAL_W-1:0] row_hist [2][CELL_COLS][BINS];
   int                   pixel_pos;
   int                   col_pos;
   int                   row_pos;
   rsp_type              norm_queue [$];
   int                   values_seen;

   // Integer square root, one result bit per step from the top
   function automatic logic [31:0] root64(input logic [63:0] x);
      logic [31:0] r;
      logic [31:0] trial;
      r = '0;
      for (int i = 31; i >= 0; i--) begin
         trial = r | (32'd1 << i);
         if (64'(trial) * 64'(trial) <= x) r = trial;
      end
      return r;
   endfunction

   // Count the 20-degree thresholds the gradient angle reaches
   function automatic int angle_bin(input logic [7:0] gx, input logic [7:0] gy);
      int n;
      n = 0;
      if (gx == 0) return 0;
      for (int k = 0; k < 4; k++)
         if ({24'd0, gy, 32'd0} >= 64'(gx) * TAN_Q32[k]) n++;
      return (n > BINS - 1) ? BINS - 1 : n;
   endfunction

   // Add one pixel; at a cell end, store it and queue the block values
   task automatic take_pixel(input req_type px);
      int                   b;
      int                   mag;
      int                   s;
      int                   rr [4];
      int                   cc [4];
      logic [BIN_VAL_W-1:0] vals [BLOCK_LEN];
      logic [63:0]          total;
      logic [63:0]          v;
      rsp_type              e;
      if (px.grad_x != 0 || px.grad_y != 0) begin
         mag = root64(64'(px.grad_x) * px.grad_x + 64'(px.grad_y) * px.grad_y);
         b = angle_bin(px.grad_x, px.grad_y);
         s = cell_hist[b] + mag;
         cell_hist[b] = BIN_VAL_W'((s > BIN_MAX) ? BIN_MAX : s);
      end
      pixel_pos++;
      if (pixel_pos < PIX_COUNT) return;
      pixel_pos = 0;
      for (int i = 0; i < BINS; i++) begin
         row_hist[row_pos % 2][col_pos][i] = cell_hist[i];
         cell_hist[i] = '0;
      end
      if (row_pos >= 1 && col_pos >= 1) begin
         rr = '{row_pos - 1, row_pos, row_pos - 1, row_pos};
         cc = '{col_pos - 1, col_pos - 1, col_pos, col_pos};
         total = '0;
         for (int q = 0; q < 4; q++)
            for (int i = 0; i < BINS; i++) begin
               vals[q*BINS + i] = row_hist[rr[q] % 2][cc[q]][i];
               total += 64'(vals[q*BINS + i]) * vals[q*BINS + i];
            end
         for (int i = 0; i < BLOCK_LEN; i++) begin
            v = '0;
            if (total != 0) begin
               v = 64'(root64(((64'(vals[i]) * vals[i]) << 32) / total));
               if (v > 64'd65535) v = 64'd65535;
            end
            e.norm_value = v[15:0];
            e.block_last = (i == BLOCK_LEN - 1);
            norm_queue = {norm_queue, e};
         end
      end
      col_pos++;
      if (col_pos >= CELL_COLS) begin
         col_pos = 0;
         row_pos = (row_pos + 1 >= CELL_ROWS) ? 0 : row_pos + 1;
      end
   endtask

   // Compare result transfers, then predict from input transfers
   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         for (int i = 0; i < BINS; i++) cell_hist[i] = '0;
         pixel_pos = 0;
         col_pos = 0;
         row_pos = 0;
         fail_count = 0;
         blocks_done = 0;
         values_seen = 0;
         norm_queue.delete();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (norm_queue.size() == 0) begin
               $error("unexpected result: norm_value %0d block_last %0d",
                      rsp_data.norm_value, rsp_data.block_last);
               fail_count++;
            end else begin
               e = norm_queue.pop_front();
               if (rsp_data.norm_value !== e.norm_value) begin
                  $error("norm_value (value %0d): expected %0d, actual %0d",
                         values_seen, e.norm_value, rsp_data.norm_value);
                  fail_count++;
               end
               if (rsp_data.block_last !== e.block_last) begin
                  $error("block_last (value %0d): expected %0d, actual %0d",
                         values_seen, e.block_last, rsp_data.block_last);
                  fail_count++;
               end
               if (e.block_last) blocks_done++;
            end
            values_seen++;
         end
         if (req_push && !req_full) take_pixel(req_data);
      end
      pending = norm_queue.size();
   end

endmodule

// ===== verif/hog_cell_histogram_block_norm_tb.sv =====
module hog_cell_histogram_block_norm_tb;
   import hog_pkg::*;

   localparam int LAST_CELL  = 11;
   localparam int QUIET_CELL = 11;
   localparam int STALL_MAX  = 20000;

   typedef enum int { CELL_MIXED, CELL_ZERO, CELL_UNIFORM } cell_kind_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   logic    req_full;
   req_type req_data = '0;
   logic    rsp_empty;
   logic    rsp_pop = 1'b0;
   rsp_type rsp_data;
   int      fail_count;
   int      pending;
   int      blocks_done;
   int      pixels_sent;
   int      idle_cycles;
   int      pop_stall;
   bit      quiet;

   always #10 clock = ~clock;

   hog_cell_histogram_block_norm dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data)
   );

   hog_norm_checker checker_i (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending(pending), .blocks_done(blocks_done)
   );

   // Drain results with random stall bursts, none near the end
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
         pop_stall <= 0;
      end else if (pop_stall > 0) begin
         rsp_pop <= 1'b0;
         pop_stall <= pop_stall - 1;
      end else begin
         rsp_pop <= 1'b1;
         if (!quiet && $urandom_range(0, 9) == 0) pop_stall <= $urandom_range(1, 6);
      end
   end

   // Abort when no transfer happens for too long
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty))
         idle_cycles <= 0;
      else if (idle_cycles >= STALL_MAX) begin
         $display("TB_ERROR");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   // Hold one pixel until it transfers, then maybe idle a burst
   task automatic send_pixel(input logic [7:0] gx, input logic [7:0] gy);
      req_push <= 1'b1;
      req_data <= '{grad_x: gx, grad_y: gy};
      do @(posedge clock); while (req_full);
      pixels_sent++;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // Random gradient: plain, zero, vertical, or right at an angle threshold
   task automatic send_random();
      logic [7:0]  gx;
      logic [7:0]  gy;
      logic [63:0] edge_y;
      case ($urandom_range(0, 9))
         0: send_pixel(8'd0, 8'd0);
         1: send_pixel(8'd0, 8'($urandom_range(0, 255)));
         2, 3: begin
            gx = 8'($urandom_range(1, 255));
            edge_y = (64'(gx) * TAN_Q32[$urandom_range(0, 3)]) >> 32;
            edge_y = edge_y + 64'($urandom_range(0, 1));
            gy = (edge_y > 255) ? 8'd255 : edge_y[7:0];
            send_pixel(gx, gy);
         end
         default: send_pixel(8'($urandom), 8'($urandom));
      endcase
   endtask

   initial begin
      cell_kind_type kind;
      logic [7:0]    ux;
      logic [7:0]    uy;
      logic [15:0]   corner [18];
      pixels_sent = 0;
      quiet = 1'b0;
      // gradient extremes, then pairs straddling each angle threshold
      corner = '{16'h0000, 16'h00FF, 16'hFF00, 16'hFFFF, 16'h0100, 16'h0001,
                 16'h01FF, 16'hFF01, {8'd100, 8'd36}, {8'd100, 8'd37},
                 {8'd100, 8'd83}, {8'd100, 8'd84}, {8'd100, 8'd173},
                 {8'd100, 8'd174}, {8'd20, 8'd113}, {8'd20, 8'd114},
                 16'hAA55, 16'h55AA};
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Block (0,1) is all zero; block (0,2) has one nonzero bin
      for (int c = 0; c <= LAST_CELL; c++) begin
         if (c >= QUIET_CELL) quiet = 1'b1;
         case (c)
            1, 2, 3, 9, 10: kind = CELL_ZERO;
            11:             kind = CELL_UNIFORM;
            default:        kind = CELL_MIXED;
         endcase
         ux = 8'($urandom_range(1, 255));
         uy = 8'($urandom);
         for (int p = 0; p < PIX_COUNT; p++) begin
            if (c == 0 && p < 18)
               send_pixel(corner[p][15:8], corner[p][7:0]);
            else if (kind == CELL_ZERO)
               send_pixel(8'd0, 8'd0);
            else if (kind == CELL_UNIFORM)
               send_pixel(ux, uy);
            else
               send_random();
         end
      end
      req_push <= 1'b0;

      // Let the checker see the last transfer, drain, then wait for strays
      @(posedge clock);
      wait (pending == 0);
      repeat (200) @(posedge clock);
      $display("Sent %0d pixels over %0d cells; checked %0d normalized blocks.",
               pixels_sent, LAST_CELL + 1, blocks_done);
      $display("Included zero-norm and single-bin blocks and angle edge cases.");
      if (fail_count == 0 && pending == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/hog_pkg.sv
rtl/hog_ram.sv
rtl/hog_isqrt.sv
rtl/hog_front.sv
rtl/hog_back.sv
rtl/hog_cell_histogram_block_norm.sv
verif/hog_norm_checker.sv
verif/hog_cell_histogram_block_norm_tb.sv
